>>> rtl/softened_gravity_acceleration_macros.svh
// ----------------------------------------------------------------------------
// softened gravity acceleration assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SOFTENED_GRAVITY_ACCELERATION_MACROS_SVH
`define SOFTENED_GRAVITY_ACCELERATION_MACROS_SVH

// same-cycle implication, checked outside reset
`define SGA_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SGA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sga_pkg.sv
// ----------------------------------------------------------------------------
// sga_pkg
// widths, constants and payload types of the softened gravity block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sga_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SQRT_GUARD  = 32;
  localparam int EPS_WIDTH   = 31;
  localparam int MUL_CHUNK   = 32;
  localparam int MUL_LAT     = 3;

  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int EPS_SQ_W  = 2 * EPS_WIDTH;
  localparam int SUM_W     = (SQ_W + 2 > EPS_SQ_W + 1) ? SQ_W + 2 : EPS_SQ_W + 1;
  localparam int ROOT_W    = (SUM_W + 1) / 2 + SQRT_GUARD;
  localparam int SQIN_W    = 2 * ROOT_W;
  localparam int DEN_W     = SUM_W + ROOT_W;
  localparam int NUM_SHIFT = 3 * FRAC_BITS + SQRT_GUARD;
  localparam int NUM_W     = DIFF_W + NUM_SHIFT;
  localparam int QUO_W     = COORD_WIDTH;
  localparam int DIV_LAT   = QUO_W + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_pos_x;
    logic signed [COORD_WIDTH-1:0] first_pos_y;
    logic signed [COORD_WIDTH-1:0] first_pos_z;
    logic signed [COORD_WIDTH-1:0] second_pos_x;
    logic signed [COORD_WIDTH-1:0] second_pos_y;
    logic signed [COORD_WIDTH-1:0] second_pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] accel_x;
    logic signed [COORD_WIDTH-1:0] accel_y;
    logic signed [COORD_WIDTH-1:0] accel_z;
    logic                          saturated;
    logic                          zero_distance;
  } out_item_t;

endpackage

>>> rtl/sga_mul.sv
// ----------------------------------------------------------------------------
// sga_mul
// unsigned multiplier built from 32x32 partial products, three stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sga_mul #(
  parameter int A_W = 33,
  parameter int B_W = 33
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int CH   = sga_pkg::MUL_CHUNK;
  localparam int NA   = (A_W + CH - 1) / CH;
  localparam int NB   = (B_W + CH - 1) / CH;
  localparam int AX_W = NA * CH;
  localparam int BX_W = NB * CH;
  localparam int P_W  = A_W + B_W;

  logic [AX_W-1:0]   a_x;
  logic [BX_W-1:0]   b_x;
  logic [2*CH-1:0]   pp_r [NA][NB];
  logic [P_W-1:0]    row_nxt [NA];
  logic [P_W-1:0]    row_r [NA];
  logic [P_W-1:0]    p_nxt;
  logic [P_W-1:0]    p_r;

  assign a_x = AX_W'(a);
  assign b_x = BX_W'(b);

  // partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= a_x[i*CH +: CH] * b_x[j*CH +: CH];
      end
    end
  end

  // one row per chunk of a
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (P_W'(pp_r[i][j]) << (j * CH));
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      p_nxt = p_nxt + (row_r[i] << (i * CH));
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

>>> rtl/sga_isqrt.sv
// ----------------------------------------------------------------------------
// sga_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sga_isqrt #(
  parameter int R_W = 66
) (
  input  logic             clk,
  input  logic [2*R_W-1:0] n,
  output logic [R_W-1:0]   root
);

  localparam int REM_W = R_W + 3;

  logic [R_W-1:0]   root_r [R_W];
  logic [REM_W-1:0] rem_r  [R_W-1];
  logic [2*R_W-1:0] n_r    [R_W-1];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [R_W-1:0]   root_in;
    logic [REM_W-1:0] rem_in;
    logic [2*R_W-1:0] n_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign n_in    = n;
    end else begin : g_next
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign n_in    = n_r[k-1];
    end

    // bring down the next two radicand bits
    assign rem_sh = {rem_in[REM_W-3:0], n_in[2*(R_W-1-k) +: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      root_r[k] <= {root_in[R_W-2:0], ge};
    end

    if (k < R_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? (rem_sh - trial) : rem_sh;
        n_r[k]   <= n_in;
      end
    end
  end

  assign root = root_r[R_W-1];

endmodule

>>> rtl/sga_div.sv
// ----------------------------------------------------------------------------
// sga_div
// one divider lane: restoring division, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sga_div #(
  parameter int N_W = 113,
  parameter int D_W = 134,
  parameter int Q_W = 32
) (
  input  logic           clk,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo,
  output logic           ovf
);

  localparam int X_W = N_W + D_W + Q_W;

  logic [X_W-1:0] num_x;
  logic           ovf_r [Q_W+1];
  logic [D_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0] lo_r  [Q_W];
  logic [D_W-1:0] den_r [Q_W];
  logic [Q_W-1:0] q_r   [1:Q_W];

  assign num_x = X_W'(num);

  // quotient too large for the lane when num >= den * 2^Q_W
  always_ff @(posedge clk) begin
    ovf_r[0] <= (num_x >= (X_W'(den) << Q_W));
    rem_r[0] <= D_W'(num_x >> Q_W);
    lo_r[0]  <= num[Q_W-1:0];
    den_r[0] <= den;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [D_W:0]   sh;
    logic           ge;
    logic [Q_W-1:0] q_in;

    if (k == 1) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = q_r[k-1];
    end

    assign sh = {rem_r[k-1], lo_r[k-1][Q_W-k]};
    assign ge = (sh >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      ovf_r[k] <= ovf_r[k-1];
      q_r[k]   <= {q_in[Q_W-2:0], ge};
    end

    if (k < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? D_W'(sh - {1'b0, den_r[k-1]}) : D_W'(sh);
        lo_r[k]  <= lo_r[k-1];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo = q_r[Q_W];
  assign ovf = ovf_r[Q_W];

endmodule

>>> rtl/softened_gravity_acceleration.sv
// ----------------------------------------------------------------------------
// softened_gravity_acceleration
// plummer-softened pairwise acceleration d / (|d|^2 + eps^2)^1.5, q16.16
// ----------------------------------------------------------------------------
//
//  channel  ports                         handshake
//  -------  ----------------------------  --------------------------------
//  input    start, busy, in_item          transfer when start & !busy
//  result   out_strobe, out_item          one cycle, strobe marks transfer
//  config   cfg_valid, cfg_ready, cfg_data transfer when valid & ready
//
// one position pair is taken every clock; busy stays low
// the pipeline depth is set mostly by the square root (one stage per
// root bit) and the three divider lanes (one stage per quotient bit)
// synchronous active-low reset clears the valid pipeline and eps
// the receiver cannot stall: each result shows for exactly one cycle
//
`timescale 1ns / 1ps
`include "softened_gravity_acceleration_macros.svh"

module softened_gravity_acceleration (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  sga_pkg::in_item_t                     in_item,
  output logic                                  out_strobe,
  output sga_pkg::out_item_t                    out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sga_pkg::EPS_WIDTH-1:0]         cfg_data
);

  localparam int DIFF_W  = sga_pkg::DIFF_W;
  localparam int SUM_W   = sga_pkg::SUM_W;
  localparam int ROOT_W  = sga_pkg::ROOT_W;
  localparam int DEN_W   = sga_pkg::DEN_W;
  localparam int NUM_W   = sga_pkg::NUM_W;
  localparam int QUO_W   = sga_pkg::QUO_W;
  localparam int EPS_W   = sga_pkg::EPS_WIDTH;

  // stage distances: side and sign from the difference register, zero flag from the sum register
  localparam int SIDE_LAT = 2 * sga_pkg::MUL_LAT + 1 + ROOT_W;
  localparam int ZERO_LAT = ROOT_W + sga_pkg::MUL_LAT + sga_pkg::DIV_LAT;
  localparam int NEG_LAT  = SIDE_LAT + sga_pkg::DIV_LAT;
  localparam int PIPE_LAT = NEG_LAT + 2;

  localparam logic [QUO_W-1:0] LIM_POS = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] LIM_NEG = {1'b1, {(QUO_W-1){1'b0}}};

  logic                       in_accept;
  logic [EPS_W-1:0]           eps_r;

  logic signed [DIFF_W-1:0]   diff [3];
  logic [2:0][DIFF_W-1:0]     dmag_nxt;
  logic [2:0]                 dneg_nxt;
  logic [2:0][DIFF_W-1:0]     dmag_r;
  logic [2:0]                 dneg_r;
  logic                       v0_r;

  logic [2*DIFF_W-1:0]        sq [3];
  logic [2*EPS_W-1:0]         sq_eps;
  logic [SUM_W-1:0]           s_r;

  logic [ROOT_W-1:0]          root;
  logic [SUM_W-1:0]           s_dly_r [ROOT_W];
  logic [DEN_W-1:0]           den;

  logic [2:0][DIFF_W-1:0]     side_r [SIDE_LAT];
  logic [2:0]                 neg_r  [NEG_LAT];
  logic                       zero_r [ZERO_LAT];
  logic                       vld_r  [NEG_LAT];

  logic [QUO_W-1:0]           quo [3];
  logic                       ovf [3];

  sga_pkg::out_item_t         out_item_nxt;
  sga_pkg::out_item_t         out_item_r;
  logic                       out_strobe_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start & ~busy;

  // softening length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  // component differences, split into sign and magnitude
  always_comb begin
    diff[0] = DIFF_W'(in_item.second_pos_x) - DIFF_W'(in_item.first_pos_x);
    diff[1] = DIFF_W'(in_item.second_pos_y) - DIFF_W'(in_item.first_pos_y);
    diff[2] = DIFF_W'(in_item.second_pos_z) - DIFF_W'(in_item.first_pos_z);
    for (int i = 0; i < 3; i++) begin
      dneg_nxt[i] = diff[i][DIFF_W-1];
      dmag_nxt[i] = dneg_nxt[i] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    dmag_r <= dmag_nxt;
    dneg_r <= dneg_nxt;
  end

  // squares of the three components and of eps, side by side
  for (genvar i = 0; i < 3; i++) begin : g_sq
    sga_mul #(.A_W(DIFF_W), .B_W(DIFF_W)) u_sq (
      .clk (clk),
      .a   (dmag_r[i]),
      .b   (dmag_r[i]),
      .p   (sq[i])
    );
  end

  sga_mul #(.A_W(EPS_W), .B_W(EPS_W)) u_sq_eps (
    .clk (clk),
    .a   (eps_r),
    .b   (eps_r),
    .p   (sq_eps)
  );

  // softened distance squared
  always_ff @(posedge clk) begin
    s_r <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq_eps);
  end

  // root of s with the guard bits
  sga_isqrt #(.R_W(ROOT_W)) u_isqrt (
    .clk  (clk),
    .n    (sga_pkg::SQIN_W'(s_r) << (2 * sga_pkg::SQRT_GUARD)),
    .root (root)
  );

  // s rides along with the root pipeline
  always_ff @(posedge clk) begin
    s_dly_r[0] <= s_r;
    for (int i = 1; i < ROOT_W; i++) begin
      s_dly_r[i] <= s_dly_r[i-1];
    end
  end

  // denominator s * root
  sga_mul #(.A_W(SUM_W), .B_W(ROOT_W)) u_den (
    .clk (clk),
    .a   (s_dly_r[ROOT_W-1]),
    .b   (root),
    .p   (den)
  );

  // magnitudes, signs, zero flag and valid follow the datapath
  always_ff @(posedge clk) begin
    side_r[0] <= dmag_r;
    for (int i = 1; i < SIDE_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
    neg_r[0] <= dneg_r;
    for (int i = 1; i < NEG_LAT; i++) begin
      neg_r[i] <= neg_r[i-1];
    end
    zero_r[0] <= (s_r == '0);
    for (int i = 1; i < ZERO_LAT; i++) begin
      zero_r[i] <= zero_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int i = 0; i < NEG_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      v0_r     <= in_accept;
      vld_r[0] <= v0_r;
      for (int i = 1; i < NEG_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // one divider lane per component
  for (genvar i = 0; i < 3; i++) begin : g_lane
    sga_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QUO_W)) u_div (
      .clk (clk),
      .num (NUM_W'(side_r[SIDE_LAT-1][i]) << sga_pkg::NUM_SHIFT),
      .den (den),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  // merge: clip each lane, restore sign, collect flags, clear all on zero distance
  always_comb begin
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag;
    logic [QUO_W-1:0] acc [3];
    logic             clip;
    logic             any_clip;
    any_clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lim      = neg_r[NEG_LAT-1][i] ? LIM_NEG : LIM_POS;
      clip     = ovf[i] | (quo[i] > lim);
      mag      = clip ? lim : quo[i];
      acc[i]   = neg_r[NEG_LAT-1][i] ? QUO_W'(-mag) : mag;
      any_clip = any_clip | clip;
    end
    if (zero_r[ZERO_LAT-1]) begin
      out_item_nxt.accel_x       = '0;
      out_item_nxt.accel_y       = '0;
      out_item_nxt.accel_z       = '0;
      out_item_nxt.saturated     = 1'b0;
      out_item_nxt.zero_distance = 1'b1;
    end else begin
      out_item_nxt.accel_x       = acc[0];
      out_item_nxt.accel_y       = acc[1];
      out_item_nxt.accel_z       = acc[2];
      out_item_nxt.saturated     = any_clip;
      out_item_nxt.zero_distance = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[NEG_LAT-1];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // every accepted pair comes out a fixed latency later, and nothing else does
  `SGA_ASSERT_IMPLIES(a_fixed_latency, clk, rst_n, in_accept, ##PIPE_LAT out_strobe, "result missing after accepted pair")
  `SGA_ASSERT_IMPLIES(a_no_phantom, clk, rst_n, out_strobe, $past(in_accept, PIPE_LAT), "result without accepted pair")
  // zero softened distance gives zero acceleration and no clip flag
  `SGA_ASSERT_IMPLIES(a_zero_out, clk, rst_n, out_strobe && out_item.zero_distance, (out_item.accel_x == '0) && (out_item.accel_y == '0) && (out_item.accel_z == '0) && !out_item.saturated, "zero distance result not cleared")
  // a config write leaves eps at the written value
  `SGA_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_valid && cfg_ready, eps_r == $past(cfg_data), "softening length not written")

endmodule
